@@ hw/rtl/lfd_pkg.sv @@
package lfd_pkg;

    localparam int MAX_PIXELS_DEF = 512;
    localparam int OUTQ_DEPTH     = 4;
    localparam int ADDR_W         = 4;

    localparam logic [7:0] SYNC_A    = 8'hFF;
    localparam logic [7:0] SYNC_B    = 8'hAA;
    localparam logic [7:0] CMD_IDENT = 8'hFE;
    localparam logic [7:0] CMD_SETID = 8'hFD;

    localparam logic [9:0]  FRAME_PIXELS_RST  = 10'd300;
    localparam logic        GRB_ORDER_RST     = 1'b1;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd50;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_FRAME_PIXELS  = 2'd0,
        REG_GRB_ORDER     = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2,
        REG_NONE          = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        K_PIXEL   = 3'd0,
        K_GOOD    = 3'd1,
        K_BAD     = 3'd2,
        K_REPLY   = 3'd3,
        K_TIMEOUT = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_SYNC2 = 4'b0010,
        PH_FRAME = 4'b0100,
        PH_SETID = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [9:0]  frame_pixels;
        logic        grb_order;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [10:0] buf_addr;
        logic [7:0]  out_byte;
        logic        last;
    } t_res;

    // rgb to grb buffer offset
    function automatic logic [1:0] grb_offset(input logic [1:0] chan);
        logic [1:0] off;
        case (chan)
            2'd0:    off = 2'd1;
            2'd1:    off = 2'd0;
            default: off = 2'd2;
        endcase
        return off;
    endfunction

endpackage

@@ hw/rtl/lfd_regs.sv @@
module lfd_regs
    import lfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_pixels  <= FRAME_PIXELS_RST;
            r_cfg.grb_order     <= GRB_ORDER_RST;
            r_cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (wr_en) begin
            case (idx)
                REG_FRAME_PIXELS:  r_cfg.frame_pixels  <= pwdata[9:0];
                REG_GRB_ORDER:     r_cfg.grb_order     <= pwdata[0];
                REG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_FRAME_PIXELS:  prdata = {22'd0, r_cfg.frame_pixels};
            REG_GRB_ORDER:     prdata = {31'd0, r_cfg.grb_order};
            REG_TIMEOUT_TICKS: prdata = {16'd0, r_cfg.timeout_ticks};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

@@ hw/rtl/lfd_core.sv @@
module lfd_core
    import lfd_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_mode,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_push0,
    output logic       o_push1,
    output t_res       o_res0,
    output t_res       o_res1
);

    t_phase      r_phase,  n_phase;
    logic [10:0] r_count,  n_count;
    logic [1:0]  r_chan,   n_chan;
    logic [7:0]  r_xor,    n_xor;
    logic [7:0]  r_id,     n_id;
    logic [15:0] r_age,    n_age;

    logic [15:0] pix_req;
    logic [15:0] pix_max;
    logic [9:0]  pix_eff;
    logic [11:0] frame_len;
    logic [15:0] age_inc;
    logic [1:0]  off;

    assign pix_req   = 16'(i_cfg.frame_pixels);
    assign pix_max   = 16'(MAX_PIXELS);
    assign pix_eff   = (pix_req > pix_max) ? pix_max[9:0] : i_cfg.frame_pixels;
    assign frame_len = 12'({pix_eff, 1'b0}) + 12'(pix_eff);
    assign age_inc   = (r_age == 16'hFFFF) ? r_age : r_age + 16'd1;
    assign off       = i_cfg.grb_order ? grb_offset(r_chan) : r_chan;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_chan  = r_chan;
        n_xor   = r_xor;
        n_id    = r_id;
        n_age   = r_age;
        o_push0 = 1'b0;
        o_push1 = 1'b0;
        o_res0  = '{kind: K_PIXEL, buf_addr: 11'd0, out_byte: 8'd0, last: 1'b1};
        o_res1  = '{kind: K_REPLY, buf_addr: 11'd0, out_byte: 8'd0, last: 1'b1};
        if (i_mode) begin
            if (r_phase == PH_FRAME) begin
                n_age = age_inc;
                if (age_inc > i_cfg.timeout_ticks) begin
                    n_phase      = PH_HUNT;
                    o_push0      = 1'b1;
                    o_res0.kind  = K_TIMEOUT;
                end
            end
        end else begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == SYNC_A) begin
                        n_phase = PH_SYNC2;
                    end else if (i_rx_byte == CMD_IDENT) begin
                        o_push0          = 1'b1;
                        o_push1          = 1'b1;
                        o_res0.kind      = K_REPLY;
                        o_res0.out_byte  = CMD_IDENT;
                        o_res0.last      = 1'b0;
                        o_res1.out_byte  = r_id;
                    end else if (i_rx_byte == CMD_SETID) begin
                        n_phase = PH_SETID;
                    end
                end
                PH_SETID: begin
                    n_id             = i_rx_byte;
                    n_phase          = PH_HUNT;
                    o_push0          = 1'b1;
                    o_push1          = 1'b1;
                    o_res0.kind      = K_REPLY;
                    o_res0.out_byte  = CMD_SETID;
                    o_res0.last      = 1'b0;
                    o_res1.out_byte  = i_rx_byte;
                end
                PH_SYNC2: begin
                    if (i_rx_byte == SYNC_B) begin
                        n_phase = PH_FRAME;
                        n_count = 11'd0;
                        n_chan  = 2'd0;
                        n_xor   = 8'd0;
                        n_age   = 16'd0;
                    end else if (i_rx_byte != SYNC_A) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_FRAME: begin
                    o_push0 = 1'b1;
                    if (12'(r_count) < frame_len) begin
                        o_res0.buf_addr = r_count - 11'(r_chan) + 11'(off);
                        o_res0.out_byte = i_rx_byte;
                        n_xor           = r_xor ^ i_rx_byte;
                        n_count         = r_count + 11'd1;
                        // channel follows the 11-bit count, also across its wrap
                        if (r_count == 11'h7FF || r_chan == 2'd2) begin
                            n_chan = 2'd0;
                        end else begin
                            n_chan = r_chan + 2'd1;
                        end
                    end else begin
                        n_phase     = PH_HUNT;
                        o_res0.kind = (r_xor == i_rx_byte) ? K_GOOD : K_BAD;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= 11'd0;
            r_chan  <= 2'd0;
            r_xor   <= 8'd0;
            r_id    <= 8'd0;
            r_age   <= 16'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_chan  <= n_chan;
            r_xor   <= n_xor;
            r_id    <= n_id;
            r_age   <= n_age;
        end
    end

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chan != 2'd3)
        else $error("colour channel counter out of range");

    a_reply_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push1 |-> (o_push0 && o_res0.kind == K_REPLY && !o_res0.last))
        else $error("second result without a leading reply");

    a_tick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_mode && r_phase != PH_FRAME) |-> !o_push0)
        else $error("tick outside a frame produced a result");

endmodule

@@ hw/rtl/lfd_outq.sv @@
module lfd_outq
    import lfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push0,
    input  logic i_push1,
    input  t_res i_res0,
    input  t_res i_res1,
    output logic o_room2,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    localparam int PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    t_res             r_mem [OUTQ_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wptr1;
    logic             pop;
    logic [1:0]       n_push;

    assign wptr1   = ptr_inc(r_wptr);
    assign pop     = o_valid && !i_stall;
    assign n_push  = {1'b0, i_push0} + {1'b0, i_push1};
    assign n_wptr  = i_push1 ? ptr_inc(wptr1) : (i_push0 ? wptr1 : r_wptr);
    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= CNT_W'(OUTQ_DEPTH - 2));
    assign o_res   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wptr] <= i_res0;
        end
        if (i_push1) begin
            r_mem[wptr1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            if (pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            r_count <= r_count + CNT_W'(n_push) - CNT_W'(pop);
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(OUTQ_DEPTH))
        else $error("result queue overfilled");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push1 |-> i_push0)
        else $error("second slot written without first");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push0 |-> r_count <= CNT_W'(OUTQ_DEPTH - 2))
        else $error("push without room for a reply pair");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push0 && !pop) |=> r_count > $past(r_count))
        else $error("queue level did not rise on push");

endmodule

@@ hw/rtl/led_frame_deframer.sv @@
// sync-framed serial receiver with xor checksum
//
// input channel: one word per serial event, i_mode 0 carries a received byte
// in i_rx_byte, i_mode 1 is one time tick. a word is taken at a clock edge with
// i_in_valid high and o_in_stall low.
// output channel: pixel writes, frame good / checksum bad / timeout status and
// reply bytes, one word per edge with o_out_valid high and i_out_stall low.
// o_last marks the final word caused by one input word.
// a word's results are written into the result queue as it is taken and are
// offered from there. throughput: one input word per cycle while o_in_stall
// is low; an identify or set-id reply puts two words out. results wait in a
// four-word queue; o_in_stall rises while the queue has fewer than two free
// words, set by that queue and the receiver's stall.
// a stalled receiver simply holds its word; nothing is lost or repeated.
// reset (synchronous, active low) returns to the sync hunt, clears unit id,
// checksum, byte count and frame age, empties the queue and loads the
// register defaults (300 pixels, grb order, 50 ticks).
// apb registers at 0x0 frame_pixels, 0x4 grb_order, 0x8 timeout_ticks; write
// them only while the block is idle.
module led_frame_deframer
    import lfd_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // apb configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input words
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic [7:0]        i_rx_byte,
    // result words
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_kind,
    output logic [10:0]       o_buf_addr,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);

    t_cfg cfg;
    t_res res0;
    t_res res1;
    t_res head;
    logic push0;
    logic push1;
    logic room2;
    logic take;

    // an input word is only taken when a reply pair would fit
    assign o_in_stall = !room2;
    assign take       = i_in_valid && room2;

    lfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lfd_core #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_mode    (i_mode),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_push0   (push0),
        .o_push1   (push1),
        .o_res0    (res0),
        .o_res1    (res1)
    );

    // core results only enter the queue for a taken word
    lfd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0 && take),
        .i_push1 (push1 && take),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (head)
    );

    assign o_kind     = head.kind;
    assign o_buf_addr = head.buf_addr;
    assign o_out_byte = head.out_byte;
    assign o_last     = head.last;

endmodule
